// File: hw/rtl/blts_pkg.sv
// Shared types and constants for the bilingual LDA token sampler.
package blts_pkg;

	localparam int TOT_W     = 24;  // topic total counter width
	localparam int PHI_W     = 17;  // word-topic ratio, Q16 capped at 0x1FFFF
	localparam int CUM_W     = 48;  // cumulative weight width
	localparam int FRAC_W    = 16;  // random fraction width
	localparam int Q8_W      = 16;  // alpha / beta width
	localparam int VOC_W     = 13;  // vocabulary size register width
	localparam int KCFG_W    = 7;   // topic count register width
	localparam int CFG_W     = 16;  // config write data width
	localparam int CFG_IDX_W = 3;
	localparam int Q_DEPTH   = 2;   // front-to-back queue depth

	localparam logic [CFG_IDX_W-1:0] REG_TOPICS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SBETA  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TBETA  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SVOCAB = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TVOCAB = 3'd5;

	localparam logic OP_ADD      = 1'b0;
	localparam logic OP_RESAMPLE = 1'b1;
	localparam logic SIDE_SRC    = 1'b0;
	localparam logic SIDE_TGT    = 1'b1;

	typedef struct packed {
		logic        op;
		logic        side;
		logic [5:0]  doc;
		logic [11:0] word;
		logic [5:0]  old;
		logic [15:0] frac;
		logic        err;
	} item_t;

	typedef struct packed {
		logic [Q8_W-1:0]  alpha;
		logic [Q8_W-1:0]  sbeta;
		logic [Q8_W-1:0]  tbeta;
		logic [VOC_W-1:0] svocab;
		logic [VOC_W-1:0] tvocab;
	} cfg_t;

endpackage

// File: hw/rtl/blts_front.sv
// Front end: takes input transfers, range-checks them and feeds the queue.
module blts_front #(
	parameter int MAX_TOPICS = 64,
	parameter int MAX_VOCAB  = 4096,
	parameter int MAX_DOCS   = 64,
	parameter int KW         = $clog2(MAX_TOPICS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 operation,
	input  logic                 language_side,
	input  logic [5:0]           doc_index,
	input  logic [11:0]          word_index,
	input  logic [5:0]           old_topic,
	input  logic [15:0]          random_fraction,
	input  logic [KW-1:0]        k_eff,
	input  blts_pkg::cfg_t       cfg,
	input  logic                 clearing,
	input  logic                 full,
	output logic                 push,
	output blts_pkg::item_t      item
);
	import blts_pkg::*;

	logic                fv_q;
	item_t               item_q;
	logic                take;
	logic                err;
	logic [VOC_W-1:0]    vocab;

	assign push     = fv_q && !full;
	assign in_stall = clearing || (fv_q && full);
	assign take     = in_valid && !in_stall;
	assign item     = item_q;

	always_comb begin
		vocab = (language_side == SIDE_TGT) ? cfg.tvocab : cfg.svocab;
		err   = (32'(old_topic) >= 32'(k_eff)) ||
		        (32'(word_index) >= 32'(vocab)) ||
		        (32'(word_index) >= MAX_VOCAB) ||
		        (32'(doc_index) >= MAX_DOCS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q <= 1'b0;
		end else if (take) begin
			fv_q <= 1'b1;
		end else if (push) begin
			fv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q.op   <= operation;
			item_q.side <= language_side;
			item_q.doc  <= doc_index;
			item_q.word <= word_index;
			item_q.old  <= old_topic;
			item_q.frac <= random_fraction;
			item_q.err  <= err;
		end
	end

endmodule

// File: hw/rtl/blts_fifo.sv
// Short queue between the front end and the sampling back end.
module blts_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  blts_pkg::item_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output blts_pkg::item_t rdata
);
	import blts_pkg::*;

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

	item_t         mem_q [Q_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   cnt_q;

	assign full  = (cnt_q == (PW+1)'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(Q_DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(Q_DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

// File: hw/rtl/blts_div.sv
// Iterative divider for the word-topic ratio, six quotient bits per cycle.
module blts_div #(
	parameter int NUM_W = 25,
	parameter int DEN_W = 33
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [NUM_W-1:0]           num,
	input  logic [DEN_W-1:0]           den,
	output logic                       done,
	output logic [blts_pkg::PHI_W-1:0] phi
);
	import blts_pkg::*;

	localparam int QW    = PHI_W + 1;
	localparam int STEP  = 6;
	localparam int NSTEP = QW / STEP;
	localparam int CW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
	localparam int CMP_W = (NUM_W > DEN_W + 2) ? NUM_W : DEN_W + 2;

	logic             run_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QW-1:0]    lo_q;
	logic [QW-1:0]    quo_q;
	logic             den_zero;
	logic             ovf;
	logic [DEN_W-1:0] r;
	logic [DEN_W:0]   t;
	logic [QW-1:0]    l;
	logic [QW-1:0]    q;

	assign den_zero = (den == '0);
	// quotient would reach 2^18, well past the cap
	assign ovf      = CMP_W'(num) >= CMP_W'({den, 2'b00});
	assign done     = done_q;
	assign phi      = quo_q[QW-1] ? '1 : quo_q[PHI_W-1:0];

	always_comb begin
		r = rem_q;
		l = lo_q;
		q = quo_q;
		for (int i = 0; i < STEP; i++) begin
			t = {r, l[QW-1]};
			l = {l[QW-2:0], 1'b0};
			if (t >= {1'b0, den_q}) begin
				t = t - {1'b0, den_q};
				q = {q[QW-2:0], 1'b1};
			end else begin
				q = {q[QW-2:0], 1'b0};
			end
			r = t[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= !(den_zero || ovf);
			done_q <= den_zero || ovf;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(NSTEP - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= DEN_W'(num >> 2);
			lo_q  <= {num[1:0], {(QW-2){1'b0}}};
			quo_q <= (ovf && !den_zero) ? '1 : '0;
		end else if (run_q) begin
			rem_q <= r;
			lo_q  <= l;
			quo_q <= q;
		end
	end

endmodule

// File: hw/rtl/blts_back.sv
// Back end: count stores, per-topic weight sweep, draw and count update.
module blts_back #(
	parameter int MAX_TOPICS = 64,
	parameter int MAX_VOCAB  = 4096,
	parameter int MAX_DOCS   = 64,
	parameter int COUNT_BITS = 16,
	parameter int KW         = $clog2(MAX_TOPICS + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [KW-1:0]   k_eff,
	input  blts_pkg::cfg_t  cfg,
	input  logic            empty,
	input  blts_pkg::item_t item,
	output logic            pop,
	output logic            clearing,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [5:0]      new_topic,
	output logic            index_error
);
	import blts_pkg::*;

	localparam int TW     = $clog2(MAX_TOPICS);
	localparam int VW     = $clog2(MAX_VOCAB);
	localparam int DDW    = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
	localparam int WA_W   = VW + TW;
	localparam int DA_W   = DDW + TW;
	localparam int CLR_W  = (WA_W > DA_W) ? WA_W : DA_W;
	localparam int CB     = COUNT_BITS;
	localparam int NUM_W  = CB + 9;
	localparam int DEN_W  = TOT_W + 9;
	localparam int VB_W   = VOC_W + Q8_W;
	localparam int DT_W   = CB + 10;
	localparam int W_W    = PHI_W + DT_W;
	localparam int SUM_W  = ((W_W > CUM_W) ? W_W : CUM_W) + 1;
	localparam int UP_W   = CUM_W + FRAC_W;
	localparam logic [SUM_W-1:0] CUM_MAX = SUM_W'({CUM_W{1'b1}});

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_RDO  = 4'd2;
	localparam logic [3:0] S_WRO  = 4'd3;
	localparam logic [3:0] S_RDK  = 4'd4;
	localparam logic [3:0] S_PREP = 4'd5;
	localparam logic [3:0] S_DIV  = 4'd6;
	localparam logic [3:0] S_MUL  = 4'd7;
	localparam logic [3:0] S_ACC  = 4'd8;
	localparam logic [3:0] S_UMUL = 4'd9;
	localparam logic [3:0] S_SRD  = 4'd10;
	localparam logic [3:0] S_SCMP = 4'd11;
	localparam logic [3:0] S_RDN  = 4'd12;
	localparam logic [3:0] S_WRN  = 4'd13;
	localparam logic [3:0] S_DONE = 4'd14;

	// count stores
	logic [CB-1:0]    swt_mem   [2**WA_W];
	logic [CB-1:0]    twt_mem   [2**WA_W];
	logic [CB-1:0]    sdt_mem   [2**DA_W];
	logic [CB-1:0]    tdt_mem   [2**DA_W];
	logic [TOT_W-1:0] stt_mem   [2**TW];
	logic [TOT_W-1:0] ttt_mem   [2**TW];
	logic [CB-1:0]    sdtot_mem [2**DDW];
	logic [CB-1:0]    tdtot_mem [2**DDW];
	logic [CUM_W-1:0] cum_mem   [2**TW];

	logic [CB-1:0]    swt_rd_q, twt_rd_q, sdt_rd_q, tdt_rd_q, sdtot_rd_q, tdtot_rd_q;
	logic [TOT_W-1:0] stt_rd_q, ttt_rd_q;
	logic [CUM_W-1:0] cum_rd_q;

	logic [3:0]       state_q;
	logic [CLR_W-1:0] clr_q;
	logic [KW-1:0]    k_q;
	logic [TW-1:0]    new_q;
	logic [CUM_W-1:0] acc_q;
	logic [CUM_W-1:0] u_q;
	item_t            it_q;
	logic [Q8_W-1:0]  beta_q;
	logic [VB_W-1:0]  vb_q;
	logic [DT_W-1:0]  dterm_q;
	logic [W_W-1:0]   prod_q;
	logic             out_valid_q;
	logic [5:0]       res_topic_q;
	logic             res_err_q;

	logic [TW-1:0]    tk;
	logic [WA_W-1:0]  wa;
	logic [DA_W-1:0]  da;
	logic [TW-1:0]    ta;
	logic [DDW-1:0]   ma;
	logic             wr_upd, dec, s_we, t_we;
	logic [CB-1:0]    wt_rd, dt_rd, dtot_rd;
	logic [TOT_W-1:0] tt_rd;
	logic [CB-1:0]    wt_wd, dt_wd, dtot_wd;
	logic [TOT_W-1:0] tt_wd;
	logic [NUM_W-1:0] num;
	logic [DEN_W-1:0] den;
	logic [DT_W-1:0]  dterm;
	logic [SUM_W-1:0] sum;
	logic [CUM_W-1:0] acc_n;
	logic [UP_W-1:0]  uprod;
	logic [VOC_W-1:0] vocab_sel;
	logic [Q8_W-1:0]  beta_sel;
	logic             div_done;
	logic [PHI_W-1:0] phi;
	logic             emit;

	assign clearing    = (state_q == S_CLR);
	assign pop         = (state_q == S_IDLE) && !empty;
	assign emit        = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign out_valid   = out_valid_q;
	assign new_topic   = res_topic_q;
	assign index_error = res_err_q;

	// topic under access in the current step
	always_comb begin
		case (state_q)
			S_RDK:        tk = k_q[TW-1:0];
			S_RDN, S_WRN: tk = new_q;
			default:      tk = TW'(it_q.old);
		endcase
		wa = clearing ? clr_q[WA_W-1:0] : {VW'(it_q.word), tk};
		da = clearing ? clr_q[DA_W-1:0] : {DDW'(it_q.doc), tk};
		ta = clearing ? clr_q[TW-1:0]   : tk;
		ma = clearing ? clr_q[DDW-1:0]  : DDW'(it_q.doc);
	end

	always_comb begin
		wr_upd  = (state_q == S_WRO) || (state_q == S_WRN);
		dec     = (state_q == S_WRO);
		s_we    = clearing || (wr_upd && (it_q.side == SIDE_SRC));
		t_we    = clearing || (wr_upd && (it_q.side == SIDE_TGT));
		wt_rd   = (it_q.side == SIDE_TGT) ? twt_rd_q : swt_rd_q;
		dt_rd   = (it_q.side == SIDE_TGT) ? tdt_rd_q : sdt_rd_q;
		tt_rd   = (it_q.side == SIDE_TGT) ? ttt_rd_q : stt_rd_q;
		dtot_rd = (it_q.side == SIDE_TGT) ? tdtot_rd_q : sdtot_rd_q;
		if (clearing) begin
			wt_wd   = '0;
			dt_wd   = '0;
			tt_wd   = '0;
			dtot_wd = '0;
		end else if (dec) begin
			wt_wd   = (wt_rd != '0) ? wt_rd - CB'(1) : wt_rd;
			dt_wd   = (dt_rd != '0) ? dt_rd - CB'(1) : dt_rd;
			tt_wd   = (tt_rd != '0) ? tt_rd - TOT_W'(1) : tt_rd;
			dtot_wd = (dtot_rd != '0) ? dtot_rd - CB'(1) : dtot_rd;
		end else begin
			wt_wd   = (&wt_rd) ? wt_rd : wt_rd + CB'(1);
			dt_wd   = (&dt_rd) ? dt_rd : dt_rd + CB'(1);
			tt_wd   = (&tt_rd) ? tt_rd : tt_rd + TOT_W'(1);
			dtot_wd = (&dtot_rd) ? dtot_rd : dtot_rd + CB'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			swt_mem[wa] <= wt_wd;
		end
		swt_rd_q <= swt_mem[wa];
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			twt_mem[wa] <= wt_wd;
		end
		twt_rd_q <= twt_mem[wa];
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			sdt_mem[da] <= dt_wd;
		end
		sdt_rd_q <= sdt_mem[da];
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			tdt_mem[da] <= dt_wd;
		end
		tdt_rd_q <= tdt_mem[da];
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			stt_mem[ta] <= tt_wd;
		end
		stt_rd_q <= stt_mem[ta];
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			ttt_mem[ta] <= tt_wd;
		end
		ttt_rd_q <= ttt_mem[ta];
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			sdtot_mem[ma] <= dtot_wd;
		end
		sdtot_rd_q <= sdtot_mem[ma];
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			tdtot_mem[ma] <= dtot_wd;
		end
		tdtot_rd_q <= tdtot_mem[ma];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ACC) begin
			cum_mem[k_q[TW-1:0]] <= acc_n;
		end
		cum_rd_q <= cum_mem[k_q[TW-1:0]];
	end

	// per-topic weight terms
	always_comb begin
		num   = NUM_W'({wt_rd, 8'h00}) + NUM_W'(beta_q);
		den   = DEN_W'({tt_rd, 8'h00}) + DEN_W'(vb_q);
		dterm = DT_W'({(CB+1)'(sdt_rd_q) + (CB+1)'(tdt_rd_q), 8'h00}) + DT_W'(cfg.alpha);
		sum   = SUM_W'(acc_q) + SUM_W'(prod_q);
		acc_n = (sum > CUM_MAX) ? '1 : sum[CUM_W-1:0];
		uprod = UP_W'(acc_q) * UP_W'(it_q.frac);
		vocab_sel = (item.side == SIDE_TGT) ? cfg.tvocab : cfg.svocab;
		beta_sel  = (item.side == SIDE_TGT) ? cfg.tbeta : cfg.sbeta;
	end

	blts_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_PREP),
		.num    (num),
		.den    (den),
		.done   (div_done),
		.phi    (phi)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!empty) begin
						if (item.err) begin
							state_q <= S_DONE;
						end else if (item.op == OP_RESAMPLE) begin
							state_q <= S_RDO;
						end else begin
							state_q <= S_RDN;
						end
					end
				end
				S_RDO:  state_q <= S_WRO;
				S_WRO:  state_q <= S_RDK;
				S_RDK:  state_q <= S_PREP;
				S_PREP: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:  state_q <= S_ACC;
				S_ACC: begin
					state_q <= (k_q + KW'(1) == k_eff) ? S_UMUL : S_RDK;
				end
				S_UMUL: state_q <= S_SRD;
				S_SRD: begin
					state_q <= (k_q == k_eff - KW'(1)) ? S_RDN : S_SCMP;
				end
				S_SCMP: begin
					state_q <= (cum_rd_q > u_q) ? S_RDN : S_SRD;
				end
				S_RDN:  state_q <= S_WRN;
				S_WRN:  state_q <= S_DONE;
				S_DONE: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				it_q   <= item;
				beta_q <= beta_sel;
				vb_q   <= VB_W'(vocab_sel) * VB_W'(beta_sel);
				k_q    <= '0;
				acc_q  <= '0;
				new_q  <= TW'(item.old);
			end
			S_PREP: dterm_q <= dterm;
			S_MUL:  prod_q  <= phi * dterm_q;
			S_ACC: begin
				acc_q <= acc_n;
				k_q   <= k_q + KW'(1);
			end
			S_UMUL: begin
				u_q <= uprod[UP_W-1:FRAC_W];
				k_q <= '0;
			end
			S_SRD: begin
				if (k_q == k_eff - KW'(1)) begin
					new_q <= k_q[TW-1:0];
				end
			end
			S_SCMP: begin
				if (cum_rd_q > u_q) begin
					new_q <= k_q[TW-1:0];
				end else begin
					k_q <= k_q + KW'(1);
				end
			end
			S_DONE: begin
				if (emit) begin
					res_topic_q <= it_q.err ? it_q.old : 6'(new_q);
					res_err_q   <= it_q.err;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: hw/rtl/bilingual_lda_gibbs_token_sampler_unit.sv
// Bilingual LDA collapsed Gibbs token sampler, top level.
// Input channel (in_valid / in_stall) carries one token per transfer: add items
// count a token under old_topic, resample items remove it, weigh every topic in
// use and draw a new one with random_fraction. The output channel (out_valid /
// out_stall) returns one result per item: new_topic and index_error.
// Out-of-range items return old_topic with index_error set and change nothing.
// A resample item runs a per-topic sweep over the K topics in use (count reads,
// divider, weight multiply, accumulate), which dominates, then searches the
// cumulative weight memory one topic at a time.
// One item is processed at a time; a front register and a two-entry queue
// take new transfers while the back end works or the result waits.
// After reset all count memories are swept to zero, one address per cycle;
// in_stall stays high during the sweep.
// A stalled result holds in the output register and the back end waits for it.
// Configuration (cfg_write, cfg_index, cfg_data) must be written only when idle; the block does not enforce this.
module bilingual_lda_gibbs_token_sampler_unit #(
	parameter int MAX_TOPICS = 64,
	parameter int MAX_VOCAB  = 4096,
	parameter int MAX_DOCS   = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               operation,
	input  logic                               language_side,
	input  logic [5:0]                         doc_index,
	input  logic [11:0]                        word_index,
	input  logic [5:0]                         old_topic,
	input  logic [15:0]                        random_fraction,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [5:0]                         new_topic,
	output logic                               index_error,
	input  logic                               cfg_write,
	input  logic [blts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [blts_pkg::CFG_W-1:0]         cfg_data
);
	import blts_pkg::*;

	localparam int KW = $clog2(MAX_TOPICS + 1);

	logic [KCFG_W-1:0] topics_q;
	cfg_t              cfg_q;
	logic [KW-1:0]     k_eff;
	logic              clearing;
	logic              push, full, pop, empty;
	item_t             f_item, q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			topics_q      <= KCFG_W'(64);
			cfg_q.alpha   <= Q8_W'(256);
			cfg_q.sbeta   <= Q8_W'(26);
			cfg_q.tbeta   <= Q8_W'(26);
			cfg_q.svocab  <= VOC_W'(4096);
			cfg_q.tvocab  <= VOC_W'(4096);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TOPICS: topics_q     <= cfg_data[KCFG_W-1:0];
				REG_ALPHA:  cfg_q.alpha  <= cfg_data;
				REG_SBETA:  cfg_q.sbeta  <= cfg_data;
				REG_TBETA:  cfg_q.tbeta  <= cfg_data;
				REG_SVOCAB: cfg_q.svocab <= cfg_data[VOC_W-1:0];
				REG_TVOCAB: cfg_q.tvocab <= cfg_data[VOC_W-1:0];
				default: ;
			endcase
		end
	end

	// zero topics acts as one, too many as the maximum
	always_comb begin
		if (topics_q == '0) begin
			k_eff = KW'(1);
		end else if (32'(topics_q) > MAX_TOPICS) begin
			k_eff = KW'(MAX_TOPICS);
		end else begin
			k_eff = KW'(topics_q);
		end
	end

	blts_front #(
		.MAX_TOPICS (MAX_TOPICS),
		.MAX_VOCAB  (MAX_VOCAB),
		.MAX_DOCS   (MAX_DOCS),
		.KW         (KW)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.language_side   (language_side),
		.doc_index       (doc_index),
		.word_index      (word_index),
		.old_topic       (old_topic),
		.random_fraction (random_fraction),
		.k_eff           (k_eff),
		.cfg             (cfg_q),
		.clearing        (clearing),
		.full            (full),
		.push            (push),
		.item            (f_item)
	);

	blts_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_item),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rdata  (q_item)
	);

	blts_back #(
		.MAX_TOPICS (MAX_TOPICS),
		.MAX_VOCAB  (MAX_VOCAB),
		.MAX_DOCS   (MAX_DOCS),
		.COUNT_BITS (COUNT_BITS),
		.KW         (KW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.k_eff       (k_eff),
		.cfg         (cfg_q),
		.empty       (empty),
		.item        (q_item),
		.pop         (pop),
		.clearing    (clearing),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.new_topic   (new_topic),
		.index_error (index_error)
	);

endmodule

// File: hw/rtl/blts_chk.sv
// Port-level checks for the token sampler, bound to the top level.
module blts_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [5:0] new_topic,
	input logic       index_error
);
	logic [3:0] pend_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	// items taken but not yet returned
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pend_q <= pend_q + 4'd1;
		end else if (out_xfer && !in_xfer) begin
			pend_q <= pend_q - 4'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(new_topic) && $stable(index_error))
		else $error("result changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> pend_q != 4'd0)
		else $error("result without a pending item");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 4'd5)
		else $error("more items in flight than storage");

	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> in_stall)
		else $error("input taken during clearing sweep");

endmodule

bind bilingual_lda_gibbs_token_sampler_unit blts_chk u_chk (.*);

// File: tb/sv/bilingual_lda_gibbs_token_sampler_unit_tb.sv
// Self-checking testbench for the bilingual LDA Gibbs token sampler.
`timescale 1ns / 1ps

module bilingual_lda_gibbs_token_sampler_unit_tb;
	import blts_pkg::*;

	localparam int NTOP = 64;
	localparam int NVOC = 4096;
	localparam logic [47:0] CUM_SAT = 48'hFFFF_FFFF_FFFF;

	typedef enum logic {ROW_TOKEN, ROW_REG} row_kind_e;

	typedef struct {
		row_kind_e   kind;
		logic        op;
		logic        side;
		logic [5:0]  doc;
		logic [11:0] word;
		logic [5:0]  old;
		logic [15:0] frac;
		logic        known;
		logic [5:0]  exp_topic;
		logic        exp_err;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_W-1:0]     reg_val;
	} stim_row_t;

	typedef struct {
		logic [5:0] topic;
		logic       err;
	} draw_t;

	typedef struct {
		logic        side;
		logic [5:0]  doc;
		logic [11:0] word;
		logic [5:0]  topic;
	} token_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_stall;
	logic operation, language_side;
	logic [5:0] doc_index, old_topic;
	logic [11:0] word_index;
	logic [15:0] random_fraction;
	logic out_valid, out_stall;
	logic [5:0] new_topic;
	logic index_error;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	bilingual_lda_gibbs_token_sampler_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .language_side(language_side),
		.doc_index(doc_index), .word_index(word_index),
		.old_topic(old_topic), .random_fraction(random_fraction),
		.out_valid(out_valid), .out_stall(out_stall),
		.new_topic(new_topic), .index_error(index_error),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow counts, indexed [side][...]
	bit [15:0] word_topic_cnt[2][NVOC*NTOP];
	bit [15:0] doc_topic_cnt[2][NTOP*NTOP];
	bit [23:0] topic_total[2][NTOP];
	bit [15:0] doc_total[2][NTOP];

	logic [6:0]  k_reg = 7'd64;
	logic [15:0] alpha_reg = 16'd256;
	logic [15:0] beta_reg[2] = '{16'd26, 16'd26};
	logic [12:0] vocab_reg[2] = '{13'd4096, 13'd4096};

	draw_t draws_due[$];
	token_t live_tokens[$];
	int mismatches = 0;
	bit no_idle = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

	function automatic int topics_eff();
		if (k_reg == 0)
			return 1;
		if (k_reg > NTOP)
			return NTOP;
		return k_reg;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Applies one token to the shadow counts and returns the drawn topic.
	task automatic draw_topic(input logic op, input logic s, input logic [5:0] d,
			input logic [11:0] wd, input logic [5:0] old, input logic [15:0] frac,
			output draw_t res);
		int kk;
		int t;
		logic [63:0] num, den, phi, dterm, w, acc, u, vb;
		logic [47:0] cum[NTOP];
		kk = topics_eff();
		vb = 64'(vocab_reg[s]);
		if (old >= kk || wd >= vocab_reg[s]) begin
			res.topic = old;
			res.err = 1'b1;
			return;
		end
		t = old;
		if (op == OP_RESAMPLE) begin
			if (word_topic_cnt[s][wd*NTOP+old] != 0) word_topic_cnt[s][wd*NTOP+old]--;
			if (doc_topic_cnt[s][d*NTOP+old] != 0) doc_topic_cnt[s][d*NTOP+old]--;
			if (topic_total[s][old] != 0) topic_total[s][old]--;
			if (doc_total[s][d] != 0) doc_total[s][d]--;
			acc = 0;
			for (int k = 0; k < kk; k++) begin
				num = 64'(word_topic_cnt[s][wd*NTOP+k]) * 256 + 64'(beta_reg[s]);
				den = 64'(topic_total[s][k]) * 256 + vb * 64'(beta_reg[s]);
				phi = 0;
				if (den != 0) begin
					phi = (num << 16) / den;
					if (phi > 64'h1FFFF)
						phi = 64'h1FFFF;
				end
				dterm = (64'(doc_topic_cnt[0][d*NTOP+k]) + 64'(doc_topic_cnt[1][d*NTOP+k]))
					* 256 + 64'(alpha_reg);
				w = phi * dterm;
				if (w > 64'(CUM_SAT) - acc)
					acc = 64'(CUM_SAT);
				else
					acc = acc + w;
				cum[k] = acc[47:0];
			end
			u = (acc * 64'(frac)) >> 16;
			for (t = 0; t + 1 < kk; t++) begin
				if (64'(cum[t]) > u)
					break;
			end
		end
		if (word_topic_cnt[s][wd*NTOP+t] != 16'hFFFF) word_topic_cnt[s][wd*NTOP+t]++;
		if (doc_topic_cnt[s][d*NTOP+t] != 16'hFFFF) doc_topic_cnt[s][d*NTOP+t]++;
		if (topic_total[s][t] != 24'hFFFFFF) topic_total[s][t]++;
		if (doc_total[s][d] != 16'hFFFF) doc_total[s][d]++;
		res.topic = t[5:0];
		res.err = 1'b0;
	endtask

	// Called at a falling edge; returns at a falling edge with valid low.
	task automatic send_token(input logic op, input logic s, input logic [5:0] d,
			input logic [11:0] wd, input logic [5:0] old, input logic [15:0] frac,
			input logic known, input draw_t typed, output draw_t res);
		if (!no_idle && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 7)) @(negedge clk);
		in_valid = 1'b1;
		operation = op;
		language_side = s;
		doc_index = d;
		word_index = wd;
		old_topic = old;
		random_fraction = frac;
		do @(posedge clk); while (in_stall);
		draw_topic(op, s, d, wd, old, frac, res);
		draws_due.push_back(known ? typed : res);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (draws_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_write = 1'b0;
		case (idx)
			REG_TOPICS: k_reg = val[6:0];
			REG_ALPHA:  alpha_reg = val;
			REG_SBETA:  beta_reg[SIDE_SRC] = val;
			REG_TBETA:  beta_reg[SIDE_TGT] = val;
			REG_SVOCAB: vocab_reg[SIDE_SRC] = val[12:0];
			REG_TVOCAB: vocab_reg[SIDE_TGT] = val[12:0];
			default: ;
		endcase
	endtask

	task automatic set_phase(input int k, input int a, input int sb, input int tb,
			input int sv, input int tv);
		wait_drained();
		write_reg(REG_TOPICS, CFG_W'(k));
		write_reg(REG_ALPHA, CFG_W'(a));
		write_reg(REG_SBETA, CFG_W'(sb));
		write_reg(REG_TBETA, CFG_W'(tb));
		write_reg(REG_SVOCAB, CFG_W'(sv));
		write_reg(REG_TVOCAB, CFG_W'(tv));
	endtask

	// result side: random stall bursts
	initial begin
		int burst;
		burst = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (burst > 0) begin
				out_stall = 1'b1;
				burst--;
			end else begin
				out_stall = 1'b0;
				if (!no_idle && $urandom_range(0, 9) == 0)
					burst = $urandom_range(1, 7);
			end
		end
	end

	always @(posedge clk) begin
		draw_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (draws_due.size() == 0) begin
				report_mismatch("unexpected transfer, topic", new_topic, -1);
			end else begin
				want = draws_due.pop_front();
				if (new_topic !== want.topic)
					report_mismatch("new_topic", new_topic, want.topic);
				if (index_error !== want.err)
					report_mismatch("index_error", index_error, want.err);
			end
		end
	end

	function automatic stim_row_t tok(input logic op, input logic s, input int d,
			input int wd, input int old, input int frac, input int known,
			input int et, input int ee);
		stim_row_t r;
		r.kind = ROW_TOKEN;
		r.op = op;
		r.side = s;
		r.doc = d[5:0];
		r.word = wd[11:0];
		r.old = old[5:0];
		r.frac = frac[15:0];
		r.known = known[0];
		r.exp_topic = et[5:0];
		r.exp_err = ee[0];
		r.reg_idx = '0;
		r.reg_val = '0;
		return r;
	endfunction

	function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
		stim_row_t r;
		r = tok(OP_ADD, SIDE_SRC, 0, 0, 0, 0, 0, 0, 0);
		r.kind = ROW_REG;
		r.reg_idx = idx;
		r.reg_val = val[CFG_W-1:0];
		return r;
	endfunction

	initial begin
		stim_row_t plan[$];
		draw_t res, typed;
		token_t tk;
		int kk, lim, pidx, r;
		logic op, s;
		logic [5:0] d, old;
		logic [11:0] wd;

		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_ADD;
		language_side = SIDE_SRC;
		doc_index = '0;
		word_index = '0;
		old_topic = '0;
		random_fraction = '0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// count stores are swept clear before the first transfer
		while (in_stall !== 1'b0)
			@(negedge clk);

		plan.push_back(tok(OP_ADD, SIDE_SRC, 0, 0, 0, 0, 1, 0, 0));
		plan.push_back(tok(OP_ADD, SIDE_TGT, 63, 4095, 63, 0, 1, 63, 0));
		plan.push_back(tok(OP_ADD, SIDE_SRC, 63, 4095, 63, 'hFFFF, 1, 63, 0));
		plan.push_back(tok(OP_RESAMPLE, SIDE_SRC, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(tok(OP_RESAMPLE, SIDE_TGT, 63, 4095, 63, 'hFFFF, 0, 0, 0));
		// never counted: decrements stop at zero
		plan.push_back(tok(OP_RESAMPLE, SIDE_SRC, 5, 7, 3, 'h8000, 0, 0, 0));
		plan.push_back(reg_row(REG_TOPICS, 4));
		plan.push_back(tok(OP_ADD, SIDE_SRC, 1, 2, 4, 0, 1, 4, 1));
		plan.push_back(tok(OP_RESAMPLE, SIDE_TGT, 1, 2, 63, 0, 1, 63, 1));
		plan.push_back(reg_row(REG_SVOCAB, 16));
		plan.push_back(tok(OP_ADD, SIDE_SRC, 1, 16, 1, 0, 1, 1, 1));
		plan.push_back(tok(OP_ADD, SIDE_SRC, 1, 15, 1, 0, 1, 1, 0));
		plan.push_back(tok(OP_RESAMPLE, SIDE_SRC, 1, 15, 1, 'h1234, 0, 0, 0));
		plan.push_back(reg_row(REG_TVOCAB, 0));
		plan.push_back(tok(OP_RESAMPLE, SIDE_TGT, 0, 0, 0, 0, 1, 0, 1));
		plan.push_back(reg_row(REG_TOPICS, 1));
		plan.push_back(tok(OP_RESAMPLE, SIDE_SRC, 1, 15, 0, 'hFFFF, 1, 0, 0));
		plan.push_back(reg_row(REG_ALPHA, 0));
		plan.push_back(reg_row(REG_SBETA, 0));
		plan.push_back(reg_row(REG_TBETA, 0));
		plan.push_back(reg_row(REG_TOPICS, 0));
		plan.push_back(tok(OP_RESAMPLE, SIDE_SRC, 2, 3, 0, 'h4000, 1, 0, 0));
		plan.push_back(tok(OP_ADD, SIDE_SRC, 2, 3, 1, 0, 1, 1, 1));
		plan.push_back(reg_row(REG_TOPICS, 127));
		plan.push_back(tok(OP_ADD, SIDE_SRC, 2, 3, 63, 0, 1, 63, 0));
		plan.push_back(reg_row(REG_SVOCAB, 4096));
		plan.push_back(reg_row(REG_TOPICS, 8));
		// unused word and document with zero priors: every weight is zero
		plan.push_back(tok(OP_RESAMPLE, SIDE_SRC, 9, 100, 2, 'h9000, 1, 7, 0));

		@(negedge clk);
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				wait_drained();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				typed.topic = plan[i].exp_topic;
				typed.err = plan[i].exp_err;
				send_token(plan[i].op, plan[i].side, plan[i].doc, plan[i].word,
					plan[i].old, plan[i].frac, plan[i].known, typed, res);
			end
		end

		for (int p = 0; p < 10; p++) begin
			case (p)
				0: set_phase(64, 256, 26, 26, 4096, 4096);
				1: set_phase(1, $urandom_range(0, 65535), 26, 26, 4096, 4096);
				2: set_phase(0, 256, $urandom_range(1, 512), 26, 64, 4096);
				3: set_phase(127, 256, 26, 26, 4096, 4096);
				4: set_phase($urandom_range(2, 8), 0, 0, 0, $urandom_range(1, 64), 32);
				5: set_phase(16, 65535, 65535, 65535, 4096, 4096);
				6: set_phase(8, 512, 40, 40, 0, 1);
				9: set_phase(64, $urandom_range(0, 2048), $urandom_range(0, 255),
					$urandom_range(0, 255), 4096, $urandom_range(1, 4096));
				default: set_phase($urandom_range(2, 32), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(1, 64), $urandom_range(1, 4096));
			endcase
			no_idle = (p == 3 || p == 9);
			for (int n = 0; n < 65; n++) begin
				kk = topics_eff();
				r = $urandom_range(0, 99);
				pidx = -1;
				op = OP_RESAMPLE;
				if (r < 15) begin
					op = 1'($urandom_range(0, 1));
					s = 1'($urandom_range(0, 1));
					d = 6'($urandom);
					wd = 12'($urandom);
					old = 6'($urandom);
				end else if (r < 50 || live_tokens.size() == 0) begin
					op = OP_ADD;
					s = 1'($urandom_range(0, 1));
					d = 6'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 7)
						: $urandom_range(0, 63));
					if (vocab_reg[s] == 0) begin
						wd = 12'($urandom);
					end else begin
						lim = ((vocab_reg[s] > NVOC) ? NVOC : vocab_reg[s]) - 1;
						wd = 12'(($urandom_range(0, 9) < 7)
							? $urandom_range(0, (lim < 15) ? lim : 15)
							: $urandom_range(0, lim));
					end
					old = 6'($urandom_range(0, kk - 1));
					pidx = -2;
				end else begin
					pidx = $urandom_range(0, live_tokens.size() - 1);
					tk = live_tokens[pidx];
					s = tk.side;
					d = tk.doc;
					wd = tk.word;
					old = tk.topic;
				end
				send_token(op, s, d, wd, old, 16'($urandom), 1'b0, typed, res);
				if (!res.err) begin
					if (pidx == -2) begin
						tk.side = s;
						tk.doc = d;
						tk.word = wd;
						tk.topic = res.topic;
						live_tokens.push_back(tk);
					end else if (pidx >= 0) begin
						live_tokens[pidx].topic = res.topic;
					end
				end
			end
		end

		while (draws_due.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
